[design/gha_pkg.sv]
// Shared types and codes for the generational handle allocator.
package gha_pkg;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_FRAME   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [8:0]  handle_id;
    logic [15:0] handle_version;
    logic        handle_is_null;
  } gha_in_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  out_id;
    logic [15:0] out_version;
    logic        is_valid;
  } gha_out_t;

endpackage

[design/gha_fifo.sv]
// Circular queue of freed slot ids with a prefetched head entry.
module gha_fifo #(
  parameter int MAX_SLOTS = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [$clog2(MAX_SLOTS)-1:0]   push_id,
  input  logic                           pop,
  output logic [$clog2(MAX_SLOTS)-1:0]   head_id,
  output logic [$clog2(MAX_SLOTS+1)-1:0] count
);

  localparam int IDW = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam logic [IDW-1:0] LAST = IDW'(MAX_SLOTS - 1);

  logic [IDW-1:0] mem [MAX_SLOTS];
  logic [IDW-1:0] head_r, head_nxt;
  logic [IDW-1:0] tail_r, tail_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IDW-1:0] head_id_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // forward a push into an empty queue straight to the head register
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_id;
    end
    if (push && tail_r == head_nxt) begin
      head_id_r <= push_id;
    end else begin
      head_id_r <= mem[head_nxt];
    end
  end

  assign head_id = head_id_r;
  assign count   = count_r;

endmodule

[design/gha_tables.sv]
// Working version table and snapshot table, each one synchronous read and one write port.
module gha_tables #(
  parameter int MAX_SLOTS    = 512,
  parameter int VERSION_BITS = 16
) (
  input  logic                         clk,
  input  logic [$clog2(MAX_SLOTS)-1:0] ver_raddr,
  output logic [VERSION_BITS-1:0]      ver_rdata,
  input  logic                         ver_we,
  input  logic [$clog2(MAX_SLOTS)-1:0] ver_waddr,
  input  logic [VERSION_BITS-1:0]      ver_wdata,
  input  logic [$clog2(MAX_SLOTS)-1:0] snap_raddr,
  output logic [VERSION_BITS-1:0]      snap_rdata,
  input  logic                         snap_we,
  input  logic [$clog2(MAX_SLOTS)-1:0] snap_waddr,
  input  logic [VERSION_BITS-1:0]      snap_wdata
);

  logic [VERSION_BITS-1:0] ver_mem  [MAX_SLOTS];
  logic [VERSION_BITS-1:0] snap_mem [MAX_SLOTS];
  logic [VERSION_BITS-1:0] ver_rdata_r;
  logic [VERSION_BITS-1:0] snap_rdata_r;

  always_ff @(posedge clk) begin
    if (ver_we) begin
      ver_mem[ver_waddr] <= ver_wdata;
    end
    ver_rdata_r <= ver_mem[ver_raddr];
  end

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[snap_waddr] <= snap_wdata;
    end
    snap_rdata_r <= snap_mem[snap_raddr];
  end

  assign ver_rdata  = ver_rdata_r;
  assign snap_rdata = snap_rdata_r;

endmodule

[design/generational_handle_allocator.sv]
// Generational handle allocator: slot create, destroy, query and snapshot copy.
//
//  channel  | ports                 | transaction
//  ---------+-----------------------+--------------------------------------
//  command  | start, busy, in_item  | taken on an edge with start high, busy low
//  result   | out_valid, out_item   | one cycle pulse, one per command
//
//  Create, destroy and query read the version tables and the prefetched head
//  of the free queue when the command is taken, then compare, write back and
//  register the result. A frame update copies the slots in use through the
//  single read port of the working table, one slot a cycle. Reset is
//  synchronous and leaves tables undefined; counts guard every read. The
//  result is shown the cycle after the last work cycle.
module generational_handle_allocator #(
  parameter int MAX_SLOTS    = 512,
  parameter int VERSION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gha_pkg::gha_in_t  in_item,
  output logic              out_valid,
  output gha_pkg::gha_out_t out_item
);

  import gha_pkg::*;

  localparam int IDW  = $clog2(MAX_SLOTS);
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;
  localparam int VCW  = (VERSION_BITS > 16) ? VERSION_BITS : 16;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_COPY = 3'b100
  } state_t;

  state_t   state_r, state_nxt;
  gha_in_t  in_r;
  logic [CW-1:0]  slots_used_r, slots_used_nxt;
  logic [CW-1:0]  snap_used_r, snap_used_nxt;
  logic [CW-1:0]  cp_r, cp_nxt;
  logic [IDW-1:0] cp_addr_r;
  logic           wr_pend_r, wr_pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  gha_out_t       out_r, out_nxt;

  logic                    accept;
  logic [IDW-1:0]          ver_raddr;
  logic [VERSION_BITS-1:0] ver_rdata;
  logic                    ver_we;
  logic [IDW-1:0]          ver_waddr;
  logic [VERSION_BITS-1:0] ver_wdata;
  logic [VERSION_BITS-1:0] snap_rdata;
  logic                    snap_we;

  logic           push, pop;
  logic [IDW-1:0] head_id;
  logic [CW-1:0]  free_count;

  logic           id_in_work, id_in_snap;
  logic           work_match, snap_match;
  logic           copy_issue;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign id_in_work = CMPW'(in_r.handle_id) < CMPW'(slots_used_r);
  assign id_in_snap = CMPW'(in_r.handle_id) < CMPW'(snap_used_r);
  assign work_match = id_in_work && (VCW'(in_r.handle_version) == VCW'(ver_rdata));
  assign snap_match = id_in_snap && (VCW'(in_r.handle_version) == VCW'(snap_rdata));
  assign copy_issue = (cp_r != slots_used_r);

  always_comb begin
    if (state_r == S_COPY) begin
      ver_raddr = cp_r[IDW-1:0];
    end else if (in_item.cmd == CMD_CREATE) begin
      ver_raddr = head_id;
    end else begin
      ver_raddr = IDW'(in_item.handle_id);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    slots_used_nxt = slots_used_r;
    snap_used_nxt  = snap_used_r;
    cp_nxt         = cp_r;
    wr_pend_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_nxt        = '0;
    out_nxt.status = ST_DONE;
    ver_we         = 1'b0;
    ver_waddr      = IDW'(in_r.handle_id);
    ver_wdata      = ver_rdata + VERSION_BITS'(1);
    push           = 1'b0;
    pop            = 1'b0;
    snap_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cp_nxt    = '0;
          state_nxt = (in_item.cmd == CMD_FRAME) ? S_COPY : S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        unique case (in_r.cmd)
          CMD_CREATE: begin
            if (free_count != '0) begin
              pop                 = 1'b1;
              out_nxt.out_id      = 9'(head_id);
              out_nxt.out_version = 16'(ver_rdata);
            end else if (slots_used_r != FULL_COUNT) begin
              ver_we         = 1'b1;
              ver_waddr      = slots_used_r[IDW-1:0];
              ver_wdata      = '0;
              slots_used_nxt = slots_used_r + 1'b1;
              out_nxt.out_id = 9'(slots_used_r[IDW-1:0]);
            end else begin
              out_nxt.status = ST_FULL;
            end
          end
          CMD_DESTROY: begin
            if (in_r.handle_is_null || !work_match || free_count == FULL_COUNT) begin
              out_nxt.status = ST_IGNORED;
            end else begin
              ver_we = 1'b1;
              push   = 1'b1;
            end
          end
          CMD_QUERY: begin
            if (in_r.handle_is_null) begin
              out_nxt.status = ST_IGNORED;
            end else begin
              out_nxt.is_valid = snap_match || work_match;
            end
          end
          CMD_FRAME: begin
          end
          default: begin
          end
        endcase
      end
      S_COPY: begin
        snap_we = wr_pend_r;
        if (copy_issue) begin
          cp_nxt      = cp_r + 1'b1;
          wr_pend_nxt = 1'b1;
        end else if (!wr_pend_r) begin
          snap_used_nxt = slots_used_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slots_used_r <= '0;
      snap_used_r  <= '0;
      cp_r         <= '0;
      wr_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      snap_used_r  <= snap_used_nxt;
      cp_r         <= cp_nxt;
      wr_pend_r    <= wr_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
    cp_addr_r <= cp_r[IDW-1:0];
    out_r     <= out_nxt;
  end

  gha_tables #(
    .MAX_SLOTS   (MAX_SLOTS),
    .VERSION_BITS(VERSION_BITS)
  ) u_tables (
    .clk       (clk),
    .ver_raddr (ver_raddr),
    .ver_rdata (ver_rdata),
    .ver_we    (ver_we),
    .ver_waddr (ver_waddr),
    .ver_wdata (ver_wdata),
    .snap_raddr(IDW'(in_item.handle_id)),
    .snap_rdata(snap_rdata),
    .snap_we   (snap_we),
    .snap_waddr(cp_addr_r),
    .snap_wdata(ver_rdata)
  );

  gha_fifo #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_id(IDW'(in_r.handle_id)),
    .pop    (pop),
    .head_id(head_id),
    .count  (free_count)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
